// ===== rtl/pr2d_pkg.sv =====
// Shared constants for the 2D point rotator: register map, angle width, sine series data.
package pr2d_pkg;

	// Angle register width, fixed by the register map
	localparam int ANGLE_WIDTH = 14;

	// Register map
	localparam int REG_IDX_WIDTH = 2;
	localparam logic [REG_IDX_WIDTH-1:0] REG_ANGLE    = 2'd0;
	localparam logic [REG_IDX_WIDTH-1:0] REG_CENTER_X = 2'd1;
	localparam logic [REG_IDX_WIDTH-1:0] REG_CENTER_Y = 2'd2;

	// Pi in unsigned Q4.60
	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

	// Taylor series for sine: term n is divided by (2n)(2n+1)
	localparam int TAYLOR_TERMS = 14;
	localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
		64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812
	};

endpackage

// ===== rtl/pr2d_trig.sv =====
// Angle reduction sequencer, quarter-wave sine ROM and cached cosine/sine registers.
module pr2d_trig #(
	parameter int TRIG_FRAC_BITS         = 15,
	parameter int ANGLE_STEPS_PER_DEGREE = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     angle_we,
	input  logic signed [pr2d_pkg::ANGLE_WIDTH-1:0]  angle,
	output logic                                     busy,
	output logic signed [TRIG_FRAC_BITS:0]           cos_value,
	output logic signed [TRIG_FRAC_BITS:0]           sin_value
);
	import pr2d_pkg::*;

	localparam int TF            = TRIG_FRAC_BITS;
	localparam int QUARTER_STEPS = 90 * ANGLE_STEPS_PER_DEGREE;
	localparam int FULL_STEPS    = 360 * ANGLE_STEPS_PER_DEGREE;
	localparam int HALF_STEPS    = 180 * ANGLE_STEPS_PER_DEGREE;
	localparam int ROM_DEPTH     = QUARTER_STEPS + 1;
	localparam int OFF_W         = $clog2(ROM_DEPTH);
	localparam int MAG_W         = ($clog2(FULL_STEPS) > ANGLE_WIDTH - 1) ?
		$clog2(FULL_STEPS) : ANGLE_WIDTH - 1;
	localparam int RED_W         = MAG_W + 1;

	localparam logic [63:0] HALF_STEPS_64 = 64'(HALF_STEPS);
	localparam logic [63:0] TRIG_SCALE_64 = (64'd1 << TF) - 64'd1;

	localparam logic signed [RED_W-1:0] FULL_R    = RED_W'(FULL_STEPS);
	localparam logic signed [RED_W-1:0] QUARTER_R = RED_W'(QUARTER_STEPS);
	localparam logic [OFF_W-1:0]        QUARTER_O = OFF_W'(QUARTER_STEPS);

	// Sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_REDUCE = 3'd1;
	localparam logic [2:0] ST_QUAD   = 3'd2;
	localparam logic [2:0] ST_READ   = 3'd3;
	localparam logic [2:0] ST_LOAD   = 3'd4;

	// Quadrant codes
	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	// Low 64 bits of (a*b) >> sh, elaboration only
	function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int sh);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return 64'(p >> sh);
	endfunction

	// Rounded, scaled sine of k steps, elaboration only
	function automatic logic [TF-1:0] sine_entry(int k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] s;
		logic [63:0] twice;
		logic [63:0] r;
		x = (PI_Q60 / HALF_STEPS_64) * 64'(k) +
			((PI_Q60 % HALF_STEPS_64) * 64'(k)) / HALF_STEPS_64;
		x2 = mul_shift(x, x, 60);
		term = x;
		sum = x;
		for (int n = 1; n <= TAYLOR_TERMS; n++) begin
			term = mul_shift(term, x2, 60) / TAYLOR_DIV[n-1];
			if (n % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		s = sum + (64'd1 << 20);
		twice = mul_shift(TRIG_SCALE_64, s, 59);
		r = (twice + 64'd1) >> 1;
		if (r > TRIG_SCALE_64) begin
			r = TRIG_SCALE_64;
		end
		return r[TF-1:0];
	endfunction

	// Quarter-wave sine ROM
	logic [TF-1:0] rom_w [ROM_DEPTH];

	for (genvar k = 0; k < ROM_DEPTH; k++) begin : g_rom
		localparam logic [TF-1:0] ENTRY = sine_entry(k);
		assign rom_w[k] = ENTRY;
	end

	logic [2:0]              state_q;
	logic signed [RED_W-1:0] red_q;
	logic [1:0]              quad_q;
	logic [TF-1:0]           fwd_q;
	logic [TF-1:0]           bwd_q;
	logic [OFF_W-1:0]        off;

	assign off  = red_q[OFF_W-1:0];
	assign busy = (state_q != ST_IDLE);

	// Reduce the angle to one turn, split into quadrant and offset, then load;
	// a new angle write restarts the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			red_q     <= '0;
			quad_q    <= QUAD_0;
			cos_value <= {1'b0, {TF{1'b1}}};
			sin_value <= '0;
		end else if (angle_we) begin
			red_q   <= RED_W'(angle);
			quad_q  <= QUAD_0;
			state_q <= ST_REDUCE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					state_q <= ST_IDLE;
				end
				ST_REDUCE: begin
					if (red_q < 0) begin
						red_q <= red_q + FULL_R;
					end else if (red_q >= FULL_R) begin
						red_q <= red_q - FULL_R;
					end else begin
						state_q <= ST_QUAD;
					end
				end
				ST_QUAD: begin
					if (red_q >= QUARTER_R) begin
						red_q  <= red_q - QUARTER_R;
						quad_q <= quad_q + 2'd1;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					unique case (quad_q)
						QUAD_0: begin
							sin_value <= $signed({1'b0, fwd_q});
							cos_value <= $signed({1'b0, bwd_q});
						end
						QUAD_1: begin
							sin_value <= $signed({1'b0, bwd_q});
							cos_value <= -$signed({1'b0, fwd_q});
						end
						QUAD_2: begin
							sin_value <= -$signed({1'b0, fwd_q});
							cos_value <= -$signed({1'b0, bwd_q});
						end
						QUAD_3: begin
							sin_value <= -$signed({1'b0, bwd_q});
							cos_value <= $signed({1'b0, fwd_q});
						end
						default: begin
							sin_value <= sin_value;
						end
					endcase
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Registered ROM reads at the offset and its complement
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			fwd_q <= rom_w[off];
			bwd_q <= rom_w[QUARTER_O - off];
		end
	end

endmodule

// ===== rtl/point_rotator_2d_unit.sv =====
// Top level: rotates each point by the cached angle and adds the center, five-stage pipeline.
//
//   channel   direction  handshake           payload
//   input     in         in_valid/in_stall   point_x, point_y, last_point
//   output    out        out_valid/out_stall screen_x, screen_y, last_out, saturated
//   config    in         wr_en               wr_index, wr_data
//
// One point per cycle while in_stall is low; out_valid rises when the point reaches stage 5.
// A stage holds its item only while the stage after it is full and cannot move.
// An angle write stalls the input in its own cycle and while the sequencer is busy: it adds or
// removes full turns, then a check; takes off quadrants, then a check; reads the ROM; and loads
// the cosine and sine.
// Reset clears all valid bits, the centers and the angle (cosine one, sine zero).
module point_rotator_2d_unit #(
	parameter int COORD_WIDTH            = 16,
	parameter int TRIG_FRAC_BITS         = 15,
	parameter int ANGLE_STEPS_PER_DEGREE = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [COORD_WIDTH-1:0]          point_x,
	input  logic signed [COORD_WIDTH-1:0]          point_y,
	input  logic                                   last_point,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [COORD_WIDTH-1:0]          screen_x,
	output logic signed [COORD_WIDTH-1:0]          screen_y,
	output logic                                   last_out,
	output logic                                   saturated,
	input  logic                                   wr_en,
	input  logic [pr2d_pkg::REG_IDX_WIDTH-1:0]     wr_index,
	input  logic [((COORD_WIDTH > pr2d_pkg::ANGLE_WIDTH) ?
		COORD_WIDTH : pr2d_pkg::ANGLE_WIDTH)-1:0] wr_data
);
	import pr2d_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int TF = TRIG_FRAC_BITS;
	localparam int P  = W + TF + 1;
	localparam int T  = W + 2;
	localparam int SW = W + 3;

	localparam logic signed [P:0]    TRUNC_BIAS = (P+1)'((64'd1 << TF) - 64'd1);
	localparam logic signed [SW-1:0] SAT_HI     = {4'b0000, {(W-1){1'b1}}};
	localparam logic signed [SW-1:0] SAT_LO     = {4'b1111, {(W-1){1'b0}}};

	// Configuration
	logic signed [W-1:0]  center_x_q;
	logic signed [W-1:0]  center_y_q;
	logic                 angle_we;
	logic                 trig_busy;
	logic signed [TF:0]   cos_value;
	logic signed [TF:0]   sin_value;

	assign angle_we = wr_en && (wr_index == REG_ANGLE);

	// Decode center writes; other indexes beyond the map are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_CENTER_X: center_x_q <= wr_data[W-1:0];
				REG_CENTER_Y: center_y_q <= wr_data[W-1:0];
				default: begin
					center_x_q <= center_x_q;
				end
			endcase
		end
	end

	pr2d_trig #(
		.TRIG_FRAC_BITS         (TRIG_FRAC_BITS),
		.ANGLE_STEPS_PER_DEGREE (ANGLE_STEPS_PER_DEGREE)
	) u_trig (
		.clk       (clk),
		.arst_n    (arst_n),
		.angle_we  (angle_we),
		.angle     (wr_data[ANGLE_WIDTH-1:0]),
		.busy      (trig_busy),
		.cos_value (cos_value),
		.sin_value (sin_value)
	);

	// Pipeline valid bits and advance chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic adv1, adv2, adv3, adv4, adv5;
	logic take;

	assign adv5 = !v_s5 || !out_stall;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;

	assign in_stall  = !adv1 || trig_busy || angle_we;
	assign take      = in_valid && !in_stall;
	assign out_valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= take;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
		end
	end

	// Stage 1: capture the transfer
	logic signed [W-1:0] px_s1, py_s1;
	logic                last_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			px_s1   <= point_x;
			py_s1   <= point_y;
			last_s1 <= last_point;
		end
	end

	// Stage 2: four products against cached cosine and sine
	logic signed [P-1:0] xc_s2, ys_s2, xs_s2, yc_s2;
	logic                last_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			xc_s2   <= P'(px_s1) * P'(cos_value);
			ys_s2   <= P'(py_s1) * P'(sin_value);
			xs_s2   <= P'(px_s1) * P'(sin_value);
			yc_s2   <= P'(py_s1) * P'(cos_value);
			last_s2 <= last_s1;
		end
	end

	// Stage 3: exact rotated sums
	logic signed [P:0] sum_x_s3, sum_y_s3;
	logic              last_s3;

	always_ff @(posedge clk) begin
		if (adv3) begin
			sum_x_s3 <= (P+1)'(xc_s2) - (P+1)'(ys_s2);
			sum_y_s3 <= (P+1)'(xs_s2) + (P+1)'(yc_s2);
			last_s3  <= last_s2;
		end
	end

	// Stage 4: shift out the fraction, truncating toward zero
	logic signed [P:0]   bias_x, bias_y;
	logic signed [P:0]   shr_x, shr_y;
	logic signed [T-1:0] rx_s4, ry_s4;
	logic                last_s4;

	assign bias_x = sum_x_s3 + (sum_x_s3[P] ? TRUNC_BIAS : '0);
	assign bias_y = sum_y_s3 + (sum_y_s3[P] ? TRUNC_BIAS : '0);
	assign shr_x  = bias_x >>> TF;
	assign shr_y  = bias_y >>> TF;

	always_ff @(posedge clk) begin
		if (adv4) begin
			rx_s4   <= shr_x[T-1:0];
			ry_s4   <= shr_y[T-1:0];
			last_s4 <= last_s3;
		end
	end

	// Stage 5: add the center, clip to the coordinate range and flag clipping
	logic signed [SW-1:0] sx, sy;
	logic                 hi_x, lo_x, hi_y, lo_y;

	assign sx   = SW'(center_x_q) + SW'(rx_s4);
	assign sy   = SW'(center_y_q) + SW'(ry_s4);
	assign hi_x = sx > SAT_HI;
	assign lo_x = sx < SAT_LO;
	assign hi_y = sy > SAT_HI;
	assign lo_y = sy < SAT_LO;

	always_ff @(posedge clk) begin
		if (adv5) begin
			screen_x  <= hi_x ? SAT_HI[W-1:0] : (lo_x ? SAT_LO[W-1:0] : sx[W-1:0]);
			screen_y  <= hi_y ? SAT_HI[W-1:0] : (lo_y ? SAT_LO[W-1:0] : sy[W-1:0]);
			last_out  <= last_s4;
			saturated <= hi_x || lo_x || hi_y || lo_y;
		end
	end

endmodule
